[sv/png_text_chunk_extractor_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the PNG text chunk extractor.
// Each macro wraps one concurrent assertion on the block clock and reset.
// ----------------------------------------------------------------------------
`ifndef PNG_TEXT_CHUNK_EXTRACTOR_CORE_MACROS_SVH
`define PNG_TEXT_CHUNK_EXTRACTOR_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTCE_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ptce: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PTCE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ptce: next-cycle check failed");

`endif

[sv/ptce_pkg.sv]
// ----------------------------------------------------------------------------
// ptce_pkg
// Types, constants and helper functions of the PNG text chunk extractor.
// ----------------------------------------------------------------------------
package ptce_pkg;

  // Parser phases.
  typedef enum logic [2:0] {
    PH_SIG  = 3'd0,
    PH_LEN  = 3'd1,
    PH_TYPE = 3'd2,
    PH_DATA = 3'd3,
    PH_CRC  = 3'd4
  } phase_t;

  // Result kinds.
  localparam logic KIND_SCENE   = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // Verdict codes.
  localparam logic [2:0] V_FOUND     = 3'd0;
  localparam logic [2:0] V_BAD_SIG   = 3'd1;
  localparam logic [2:0] V_CRC_ERR   = 3'd2;
  localparam logic [2:0] V_NOT_FOUND = 3'd3;
  localparam logic [2:0] V_REJECTED  = 3'd4;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_MID   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SCENE = 3'd4;

  // Keyword geometry.
  localparam int unsigned KEY_MAX_BYTES = 24;
  localparam int unsigned KEY_IDX_W     = 5;
  localparam int unsigned PLEN_W        = 6;
  localparam logic [KEY_IDX_W-1:0] KEY_MAX_LEN   = 5'd24;
  localparam logic [PLEN_W-1:0]    PREFIX_ZEROS  = 6'd5;

  // Stream constants.
  localparam logic [31:0] CRC_POLY  = 32'hedb88320;
  localparam logic [31:0] CRC_INIT  = 32'hffffffff;
  localparam logic [31:0] TYPE_ITXT = 32'h69545874;
  localparam logic [31:0] TYPE_IEND = 32'h49454e44;
  localparam logic [31:0] SIG_LEN   = 32'd8;
  localparam logic [31:0] FIELD_LEN = 32'd4;
  localparam logic [24:0] SCENE_SAT = 25'h1ffffff;
  localparam logic [23:0] MAX_SCENE_RESET = 24'hffffff;

  // Expected byte of the PNG signature at a given position.
  function automatic logic [7:0] sig_byte(input logic [2:0] pos);
    logic [7:0] b;
    case (pos)
      3'd0:    b = 8'h89;
      3'd1:    b = 8'h50;
      3'd2:    b = 8'h4e;
      3'd3:    b = 8'h47;
      3'd4:    b = 8'h0d;
      3'd5:    b = 8'h0a;
      3'd6:    b = 8'h1a;
      default: b = 8'h0a;
    endcase
    return b;
  endfunction

  // One byte of the reflected CRC-32, bit by bit.
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

[sv/png_text_chunk_extractor_core.sv]
// ----------------------------------------------------------------------------
// PNG text chunk extractor core
// Walks a PNG byte stream, checks signature and chunk CRCs, and extracts the
// payload of the iTXt chunk that carries the configured keyword.
// ----------------------------------------------------------------------------
// The block takes one image byte per clock cycle unless the output stalls
// and gives at most one result per byte, via the input and result registers
// with the CRC-32 byte update and the field counters computed between them.
// Scene bytes of the target chunk appear as they arrive; one verdict per
// image follows and later bytes are dropped until the byte marked as the
// end of the image. The user must write configuration through the plain
// write port only while no image is in progress; the block does not enforce it.
`include "png_text_chunk_extractor_core_macros.svh"

module png_text_chunk_extractor_core
  import ptce_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Input channel.
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            data_byte,
  input  logic                  end_of_image,
  // Output channel.
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_kind,
  output logic [7:0]            scene_byte,
  output logic [2:0]            verdict,
  output logic                  run_end,
  // Configuration write port.
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers.
  logic [63:0] key_low, key_mid, key_high;
  logic [4:0]  key_len;
  logic [23:0] max_scene;

  // Input register.
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_eoi;

  // Parser state and next values.
  phase_t      phase, phase_next;
  logic [31:0] field_count, field_count_next;
  logic [31:0] chunk_length, chunk_length_next;
  logic [31:0] chunk_type, chunk_type_next;
  logic [31:0] running_crc, running_crc_next;
  logic [31:0] received_crc, received_crc_next;
  logic        is_text, is_text_next;
  logic        prefix_matched, prefix_matched_next;
  logic [24:0] scene_count, scene_count_next;
  logic        verdict_given;

  // Step signals.
  logic                 fire;
  logic [31:0]          fc_inc;
  logic [KEY_IDX_W-1:0] key_len_eff;
  logic [PLEN_W-1:0]    plen;
  logic [7:0]           key_bytes [KEY_MAX_BYTES];
  logic [31:0]          type_shift, rc_shift, crc_upd;
  logic                 sig_bad, last_field, crc_bad, is_target;
  logic                 raw_verdict, raw_scene;
  logic [2:0]           raw_code;
  logic                 give_verdict, give_scene;
  logic [2:0]           final_code;

  // The input register advances when the result register is free or drains.
  assign fire     = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || fire;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_low   <= '0;
      key_mid   <= '0;
      key_high  <= '0;
      key_len   <= '0;
      max_scene <= MAX_SCENE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_KEY_LOW:   key_low   <= cfg_data;
        REG_KEY_MID:   key_mid   <= cfg_data;
        REG_KEY_HIGH:  key_high  <= cfg_data;
        REG_KEY_LEN:   key_len   <= cfg_data[4:0];
        REG_MAX_SCENE: max_scene <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // Keyword bytes, saturated length and full prefix length.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      key_bytes[i]      = key_low[8*i +: 8];
      key_bytes[i + 8]  = key_mid[8*i +: 8];
      key_bytes[i + 16] = key_high[8*i +: 8];
    end
  end
  assign key_len_eff = (key_len > KEY_MAX_LEN) ? KEY_MAX_LEN : key_len;
  assign plen        = {1'b0, key_len_eff} + PREFIX_ZEROS;

  // Shared arithmetic of one step.
  assign fc_inc     = field_count + 32'd1;
  assign type_shift = {chunk_type[23:0], s1_byte};
  assign rc_shift   = {received_crc[23:0], s1_byte};
  assign crc_upd    = crc32_byte(running_crc, s1_byte);
  assign sig_bad    = s1_byte != sig_byte(field_count[2:0]);
  assign last_field = fc_inc >= FIELD_LEN;
  assign crc_bad    = (running_crc ^ CRC_INIT) != rc_shift;
  assign is_target  = is_text && prefix_matched && (chunk_length >= {26'h0, plen});

  // Results that the byte causes within its phase.
  always_comb begin
    raw_verdict = 1'b0;
    raw_scene   = 1'b0;
    raw_code    = V_FOUND;
    unique case (phase)
      PH_SIG: begin
        if (sig_bad) begin
          raw_verdict = 1'b1;
          raw_code    = V_BAD_SIG;
        end
      end
      PH_DATA: begin
        raw_scene = is_text && prefix_matched && (field_count >= {26'h0, plen});
      end
      PH_CRC: begin
        if (last_field) begin
          if (crc_bad) begin
            raw_verdict = 1'b1;
            raw_code    = V_CRC_ERR;
          end else if (is_target) begin
            raw_verdict = 1'b1;
            raw_code    = (scene_count == '0 || scene_count > {1'b0, max_scene}) ?
                          V_REJECTED : V_FOUND;
          end else if (chunk_type == TYPE_IEND) begin
            raw_verdict = 1'b1;
            raw_code    = V_NOT_FOUND;
          end
        end
      end
      default: ;
    endcase
  end

  // Next state of the parser.
  always_comb begin
    phase_next          = phase;
    field_count_next    = field_count;
    chunk_length_next   = chunk_length;
    chunk_type_next     = chunk_type;
    running_crc_next    = running_crc;
    received_crc_next   = received_crc;
    is_text_next        = is_text;
    prefix_matched_next = prefix_matched;
    scene_count_next    = scene_count;
    unique case (phase)
      PH_SIG: begin
        if (!sig_bad) begin
          if (fc_inc >= SIG_LEN) begin
            phase_next        = PH_LEN;
            field_count_next  = '0;
            chunk_length_next = '0;
          end else begin
            field_count_next = fc_inc;
          end
        end
      end
      PH_LEN: begin
        chunk_length_next = {chunk_length[23:0], s1_byte};
        if (last_field) begin
          phase_next       = PH_TYPE;
          field_count_next = '0;
          chunk_type_next  = '0;
          running_crc_next = CRC_INIT;
        end else begin
          field_count_next = fc_inc;
        end
      end
      PH_TYPE: begin
        running_crc_next = crc_upd;
        chunk_type_next  = type_shift;
        if (last_field) begin
          field_count_next    = '0;
          is_text_next        = type_shift == TYPE_ITXT;
          prefix_matched_next = 1'b1;
          scene_count_next    = '0;
          received_crc_next   = '0;
          phase_next          = (chunk_length != '0) ? PH_DATA : PH_CRC;
        end else begin
          field_count_next = fc_inc;
        end
      end
      PH_DATA: begin
        running_crc_next = crc_upd;
        // Keyword bytes, then the zero bytes, then the scene.
        if (is_text) begin
          if (field_count < {27'h0, key_len_eff}) begin
            if (s1_byte != key_bytes[field_count[KEY_IDX_W-1:0]]) begin
              prefix_matched_next = 1'b0;
            end
          end else if (field_count < {26'h0, plen}) begin
            if (s1_byte != 8'h00) begin
              prefix_matched_next = 1'b0;
            end
          end else if (prefix_matched && scene_count != SCENE_SAT) begin
            scene_count_next = scene_count + 25'd1;
          end
        end
        if (fc_inc >= chunk_length) begin
          phase_next       = PH_CRC;
          field_count_next = '0;
        end else begin
          field_count_next = fc_inc;
        end
      end
      PH_CRC: begin
        received_crc_next = rc_shift;
        if (last_field) begin
          field_count_next = '0;
          if (!raw_verdict) begin
            phase_next        = PH_LEN;
            chunk_length_next = '0;
          end
        end else begin
          field_count_next = fc_inc;
        end
      end
      default: begin
        phase_next       = PH_SIG;
        field_count_next = '0;
      end
    endcase
  end

  // The end of the image forces a verdict and drops a pending scene byte.
  assign give_verdict = !verdict_given && (raw_verdict || s1_eoi);
  assign give_scene   = !verdict_given && raw_scene && !s1_eoi;
  assign final_code   = raw_verdict ? raw_code :
                        ((phase_next == PH_SIG) ? V_BAD_SIG : V_NOT_FOUND);

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_byte <= data_byte;
      s1_eoi  <= end_of_image;
    end
  end

  // Parser state update; the end of the image clears the parser.
  always_ff @(posedge clk) begin
    if (rst || (fire && s1_eoi)) begin
      phase          <= PH_SIG;
      field_count    <= '0;
      chunk_length   <= '0;
      chunk_type     <= '0;
      running_crc    <= CRC_INIT;
      received_crc   <= '0;
      is_text        <= 1'b0;
      prefix_matched <= 1'b1;
      scene_count    <= '0;
      verdict_given  <= 1'b0;
    end else if (fire && !verdict_given) begin
      phase          <= phase_next;
      field_count    <= field_count_next;
      chunk_length   <= chunk_length_next;
      chunk_type     <= chunk_type_next;
      running_crc    <= running_crc_next;
      received_crc   <= received_crc_next;
      is_text        <= is_text_next;
      prefix_matched <= prefix_matched_next;
      scene_count    <= scene_count_next;
      verdict_given  <= give_verdict;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= give_verdict || give_scene;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (fire) begin
      out_kind   <= give_verdict ? KIND_VERDICT : KIND_SCENE;
      scene_byte <= give_verdict ? 8'h00 : s1_byte;
      verdict    <= give_verdict ? final_code : V_FOUND;
      run_end    <= give_verdict && s1_eoi;
    end
  end

  // Checks.
  `PTCE_ASSERT_IMP(a_scene_fields, clk, rst, out_valid && out_kind == KIND_SCENE, verdict == V_FOUND && !run_end)
  `PTCE_ASSERT_IMP(a_verdict_range, clk, rst, out_valid && out_kind == KIND_VERDICT, verdict <= V_REJECTED)
  `PTCE_ASSERT_IMP(a_sig_count, clk, rst, phase == PH_SIG, field_count < SIG_LEN)
  `PTCE_ASSERT_NEXT(a_verdict_latch, clk, rst, fire && give_verdict && !s1_eoi, verdict_given)

endmodule
